FILE: rtl/rmp_pkg.sv
// ----------------------------------------------------------------------------
// rmp_pkg
// Shared constants, types and the CORDIC angle table of the Rouse mode
// projection block.
// ----------------------------------------------------------------------------
package rmp_pkg;

  localparam int MAX_BEADS    = 4096;
  localparam int CORDIC_STEPS = 16;

  // Field and register widths.
  localparam int POS_W     = 32;
  localparam int MODE_W    = 48;
  localparam int CHAIN_W   = 16;
  localparam int COUNT_W   = 13;
  localparam int STEP_W    = 24;
  localparam int NORM_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;
  localparam int SUM_W     = 64;

  // Bead index and the width used to compare it with the chain length.
  localparam int BEAD_W = $clog2(MAX_BEADS);
  localparam int CMP_W  = (BEAD_W + 1 > COUNT_W) ? BEAD_W + 1 : COUNT_W;

  // CORDIC datapath.
  localparam int XW       = 34;
  localparam int ATAN_W   = 30;
  localparam int TBL_IDX  = 5;
  localparam int W_W      = 18;
  localparam int MUL_A_W  = 33;
  localparam int MUL_B_W  = 18;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int HI_W     = 48;
  localparam int FIN_W    = 50;
  localparam int CNT_W    = $clog2(CORDIC_STEPS);

  localparam logic signed [XW-1:0] CORDIC_START = XW'(652032874);

  // Reset values of the configuration registers.
  localparam logic [COUNT_W-1:0] BEAD_COUNT_RST = COUNT_W'(16);
  localparam logic [STEP_W-1:0]  ANGLE_STEP_RST = STEP_W'(524288);
  localparam logic [NORM_W-1:0]  NORM_SCALE_RST = NORM_W'(23170);

  // Sequencer terminal counts.
  localparam logic [CNT_W-1:0] ROT_LAST = CNT_W'(CORDIC_STEPS - 1);
  localparam logic [CNT_W-1:0] MAC_LAST = CNT_W'(3);
  localparam logic [CNT_W-1:0] FIN_LAST = CNT_W'(6);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BEAD_COUNT = 2'd0,
    REG_ANGLE_STEP = 2'd1,
    REG_NORM_SCALE = 2'd2
  } rmp_reg_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic             accept;
    logic             rot;
    logic             cos;
    logic             mac;
    logic             fin;
    logic [CNT_W-1:0] step;
  } rmp_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic last;
  } rmp_stat_t;

  // Arctangent of 2^-i with 2^32 units per turn.
  function automatic logic [ATAN_W-1:0] atan_turns(input logic [TBL_IDX-1:0] idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      5'd0:    val = 30'd536870912;
      5'd1:    val = 30'd316933406;
      5'd2:    val = 30'd167458907;
      5'd3:    val = 30'd85004756;
      5'd4:    val = 30'd42667331;
      5'd5:    val = 30'd21354465;
      5'd6:    val = 30'd10679838;
      5'd7:    val = 30'd5340245;
      5'd8:    val = 30'd2670163;
      5'd9:    val = 30'd1335087;
      5'd10:   val = 30'd667544;
      5'd11:   val = 30'd333772;
      5'd12:   val = 30'd166886;
      5'd13:   val = 30'd83443;
      5'd14:   val = 30'd41722;
      5'd15:   val = 30'd20861;
      5'd16:   val = 30'd10430;
      5'd17:   val = 30'd5215;
      5'd18:   val = 30'd2608;
      5'd19:   val = 30'd1304;
      5'd20:   val = 30'd652;
      5'd21:   val = 30'd326;
      5'd22:   val = 30'd163;
      5'd23:   val = 30'd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/rouse_mode_projection_top.sv
// ----------------------------------------------------------------------------
// rouse_mode_projection_top
// Rouse normal-mode projection of bead chains.
// ----------------------------------------------------------------------------
// Each request carries one bead position. The block weights it by the
// cosine of the bead's mode angle and adds it into three 64-bit saturating
// sums; the last bead of a chain produces one mode vector with its chain
// number. For a bead that does not end a chain, the cosine comes from a
// single CORDIC shift-add stage iterated CORDIC_STEPS times, followed by
// three multiply-accumulates on one shared 33x18 multiplier. A bead that
// ends a chain adds final scaling on the same multiplier, which begins only
// once the previous result has left the output register. The output
// register holds a finished result while the next beads are taken in.
// Configuration is written through the plain write port; the user must do
// so only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module rouse_mode_projection_top
  import rmp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [POS_W-1:0]  pos_x_i,
  input  logic signed [POS_W-1:0]  pos_y_i,
  input  logic signed [POS_W-1:0]  pos_z_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [MODE_W-1:0] mode_x_o,
  output logic signed [MODE_W-1:0] mode_y_o,
  output logic signed [MODE_W-1:0] mode_z_o,
  output logic [CHAIN_W-1:0]       chain_number_o
);

  rmp_cmd_t  cmd;
  rmp_stat_t stat;

  rmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rmp_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .mode_x_o       (mode_x_o),
    .mode_y_o       (mode_y_o),
    .mode_z_o       (mode_z_o),
    .chain_number_o (chain_number_o)
  );

endmodule

FILE: rtl/rmp_ctrl.sv
// ----------------------------------------------------------------------------
// rmp_ctrl
// Sequencer: accepts a request, steps the CORDIC, the three multiply-
// accumulates and the end-of-chain scaling, and owns the result valid.
// ----------------------------------------------------------------------------
module rmp_ctrl
  import rmp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  rmp_stat_t stat_i,
  output rmp_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ROT  = 5'b00010,
    S_COS  = 5'b00100,
    S_MAC  = 5'b01000,
    S_FIN  = 5'b10000
  } rmp_state_e;

  rmp_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.step  = cnt_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_ROT;
          cnt_d        = '0;
        end
      end
      S_ROT: begin
        cmd_o.rot = 1'b1;
        if (cnt_q == ROT_LAST) begin
          state_d = S_COS;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_COS: begin
        cmd_o.cos = 1'b1;
        state_d   = S_MAC;
        cnt_d     = '0;
      end
      S_MAC: begin
        cmd_o.mac = 1'b1;
        if (cnt_q == MAC_LAST) begin
          cnt_d   = '0;
          state_d = stat_i.last ? S_FIN : S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        // The scaling writes the output registers, so it starts only once
        // the previous result has been taken.
        if (cnt_q == '0 && out_valid_q) begin
          cnt_d = cnt_q;
        end else if (cnt_q == FIN_LAST) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/rmp_datapath.sv
// ----------------------------------------------------------------------------
// rmp_datapath
// Configuration registers, bead and phase counters, the shared CORDIC
// stage, one shared multiplier and the saturating sums and scaling.
// ----------------------------------------------------------------------------
module rmp_datapath
  import rmp_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]            cfg_data_i,
  input  logic signed [POS_W-1:0]     pos_x_i,
  input  logic signed [POS_W-1:0]     pos_y_i,
  input  logic signed [POS_W-1:0]     pos_z_i,
  input  rmp_cmd_t                    cmd_i,
  output rmp_stat_t                   stat_o,
  output logic signed [MODE_W-1:0]    mode_x_o,
  output logic signed [MODE_W-1:0]    mode_y_o,
  output logic signed [MODE_W-1:0]    mode_z_o,
  output logic [CHAIN_W-1:0]          chain_number_o
);

  localparam logic signed [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [MODE_W-1:0] MODE_MAX = {1'b0, {(MODE_W-1){1'b1}}};
  localparam logic signed [MODE_W-1:0] MODE_MIN = {1'b1, {(MODE_W-1){1'b0}}};

  // Configuration.
  logic [COUNT_W-1:0] bead_count_q;
  logic [STEP_W-1:0]  angle_step_q;
  logic [NORM_W-1:0]  norm_scale_q;

  // Chain state.
  logic [BEAD_W-1:0]  bead_idx_q;
  logic [STEP_W-1:0]  phase_q;
  logic [CHAIN_W-1:0] chain_q;
  logic               last_q;

  // Item payload and CORDIC state.
  logic signed [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic signed [XW-1:0]    x_q, y_q, z_q;
  logic                    neg_q;
  logic signed [W_W-1:0]   w_q;

  logic signed [SUM_W-1:0]  sum_x_q, sum_y_q, sum_z_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [HI_W-1:0]   hi_q;

  logic signed [MODE_W-1:0] mode_x_q, mode_y_q, mode_z_q;
  logic [CHAIN_W-1:0]       chain_out_q;

  // ---------------------------------------------------------------- accept
  logic [CMP_W-1:0]  len;
  logic [CMP_W-1:0]  idx_next;
  logic              last_d;
  logic [24:0]       ang25;
  logic [31:0]       ang32;
  logic [31:0]       ang_test;
  logic [31:0]       ang_fold;

  always_comb begin
    if (CMP_W'(bead_count_q) < CMP_W'(2)) begin
      len = CMP_W'(2);
    end else if (CMP_W'(bead_count_q) > CMP_W'(MAX_BEADS)) begin
      len = CMP_W'(MAX_BEADS);
    end else begin
      len = CMP_W'(bead_count_q);
    end
    idx_next = CMP_W'(bead_idx_q) + 1'b1;
    last_d   = (idx_next >= len);
    // Half-step offset: angle = 2*phase + step in Q0.25 turns.
    ang25    = {phase_q, 1'b0} + {1'b0, angle_step_q};
    ang32    = {ang25, 7'b0};
    ang_test = ang32 + 32'h4000_0000;
    ang_fold = ang_test[31] ? (ang32 ^ 32'h8000_0000) : ang32;
  end

  // ------------------------------------------------------------- CORDIC
  logic signed [XW-1:0] xs, ys, at;
  logic signed [XW-1:0] x_rot, y_rot, z_rot;

  always_comb begin
    xs = x_q >>> cmd_i.step;
    ys = y_q >>> cmd_i.step;
    at = $signed({{(XW-ATAN_W){1'b0}}, atan_turns(TBL_IDX'(cmd_i.step))});
    if (!z_q[XW-1]) begin
      x_rot = x_q - ys;
      y_rot = y_q + xs;
      z_rot = z_q - at;
    end else begin
      x_rot = x_q + ys;
      y_rot = y_q - xs;
      z_rot = z_q + at;
    end
  end

  // Cosine rounded to Q.16.
  logic signed [XW-1:0] x_fin;
  logic signed [XW-1:0] x_rnd;

  always_comb begin
    x_fin = neg_q ? -x_q : x_q;
    x_rnd = x_fin + XW'(8192);
  end

  // ---------------------------------------------------- shared multiplier
  logic [1:0]                rd_sel;
  logic signed [SUM_W-1:0]   sum_rd;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_d;
  logic [CNT_W-1:0]          step_dec;

  always_comb begin
    step_dec = cmd_i.step - 1'b1;
    if (cmd_i.fin) begin
      rd_sel = 2'(cmd_i.step >> 1);
    end else begin
      rd_sel = 2'(step_dec);
    end
    case (rd_sel)
      2'd0:    sum_rd = sum_x_q;
      2'd1:    sum_rd = sum_y_q;
      2'd2:    sum_rd = sum_z_q;
      default: sum_rd = '0;
    endcase

    mul_a = '0;
    mul_b = '0;
    if (cmd_i.fin) begin
      // Even steps take the upper word of a sum, odd steps the lower one.
      mul_a = cmd_i.step[0] ? $signed({1'b0, sum_rd[31:0]})
                            : $signed({sum_rd[SUM_W-1], sum_rd[SUM_W-1:32]});
      mul_b = $signed({{(MUL_B_W-NORM_W){1'b0}}, norm_scale_q});
    end else begin
      case (cmd_i.step)
        CNT_W'(0): mul_a = MUL_A_W'(pos_x_q);
        CNT_W'(1): mul_a = MUL_A_W'(pos_y_q);
        CNT_W'(2): mul_a = MUL_A_W'(pos_z_q);
        default:   mul_a = '0;
      endcase
      mul_b = w_q;
    end
    prod_d = mul_a * mul_b;
  end

  // Saturating accumulate of the registered product.
  logic signed [SUM_W:0]   acc_wide;
  logic signed [SUM_W-1:0] acc_sat;

  always_comb begin
    acc_wide = {sum_rd[SUM_W-1], sum_rd} + (SUM_W+1)'(prod_q);
    if (acc_wide[SUM_W] != acc_wide[SUM_W-1]) begin
      acc_sat = acc_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      acc_sat = acc_wide[SUM_W-1:0];
    end
  end

  // Final scaling: hi*scale plus the rounded upper part of lo*scale.
  logic [HI_W:0]            lo_rnd;
  logic signed [FIN_W-1:0]  fin_wide;
  logic signed [MODE_W-1:0] fin_sat;
  logic [CNT_W-1:0]         fin_comp;

  always_comb begin
    lo_rnd   = {1'b0, prod_q[HI_W-1:0]} + (HI_W+1)'(33'h0_8000_0000);
    fin_wide = FIN_W'(hi_q) + $signed({{(FIN_W-(HI_W+1-32)){1'b0}}, lo_rnd[HI_W:32]});
    if (fin_wide > FIN_W'(MODE_MAX)) begin
      fin_sat = MODE_MAX;
    end else if (fin_wide < FIN_W'(MODE_MIN)) begin
      fin_sat = MODE_MIN;
    end else begin
      fin_sat = fin_wide[MODE_W-1:0];
    end
    fin_comp = (cmd_i.step >> 1) - 1'b1;
  end

  logic fin_write;
  assign fin_write = cmd_i.fin && !cmd_i.step[0] && (cmd_i.step != '0);

  // ----------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bead_count_q <= BEAD_COUNT_RST;
      angle_step_q <= ANGLE_STEP_RST;
      norm_scale_q <= NORM_SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BEAD_COUNT: bead_count_q <= cfg_data_i[COUNT_W-1:0];
        REG_ANGLE_STEP: angle_step_q <= cfg_data_i[STEP_W-1:0];
        REG_NORM_SCALE: norm_scale_q <= cfg_data_i[NORM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bead_idx_q <= '0;
      phase_q    <= '0;
      chain_q    <= '0;
      last_q     <= 1'b0;
      sum_x_q    <= '0;
      sum_y_q    <= '0;
      sum_z_q    <= '0;
    end else begin
      if (cmd_i.accept) begin
        last_q <= last_d;
        if (last_d) begin
          bead_idx_q <= '0;
          phase_q    <= '0;
        end else begin
          bead_idx_q <= idx_next[BEAD_W-1:0];
          phase_q    <= phase_q + angle_step_q;
        end
      end
      if (cmd_i.mac && cmd_i.step != '0) begin
        case (rd_sel)
          2'd0:    sum_x_q <= acc_sat;
          2'd1:    sum_y_q <= acc_sat;
          2'd2:    sum_z_q <= acc_sat;
          default: ;
        endcase
      end
      if (cmd_i.fin && cmd_i.step == FIN_LAST) begin
        sum_x_q <= '0;
        sum_y_q <= '0;
        sum_z_q <= '0;
        chain_q <= chain_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
      pos_z_q <= pos_z_i;
      x_q     <= CORDIC_START;
      y_q     <= '0;
      z_q     <= XW'($signed(ang_fold));
      neg_q   <= ang_test[31];
    end else if (cmd_i.rot) begin
      x_q <= x_rot;
      y_q <= y_rot;
      z_q <= z_rot;
    end
    if (cmd_i.cos) begin
      w_q <= x_rnd[14+W_W-1:14];
    end
    prod_q <= prod_d;
    if (cmd_i.fin && cmd_i.step[0]) begin
      hi_q <= prod_q[HI_W-1:0];
    end
    if (fin_write) begin
      case (fin_comp)
        CNT_W'(0): mode_x_q <= fin_sat;
        CNT_W'(1): mode_y_q <= fin_sat;
        CNT_W'(2): mode_z_q <= fin_sat;
        default: ;
      endcase
    end
    if (cmd_i.fin && cmd_i.step == FIN_LAST) begin
      chain_out_q <= chain_q;
    end
  end

  assign stat_o.last    = last_q;
  assign mode_x_o       = mode_x_q;
  assign mode_y_o       = mode_y_q;
  assign mode_z_o       = mode_z_q;
  assign chain_number_o = chain_out_q;

endmodule

FILE: rtl/rmp_checker.sv
// ----------------------------------------------------------------------------
// rmp_checker
// Port-level checks of the Rouse mode projection block, bound to its top.
// ----------------------------------------------------------------------------
module rmp_checker
  import rmp_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [MODE_W-1:0] mode_x_o,
  input logic signed [MODE_W-1:0] mode_y_o,
  input logic signed [MODE_W-1:0] mode_z_o,
  input logic [CHAIN_W-1:0]       chain_number_o
);

  logic               in_acc;
  logic               out_acc;
  logic               seen_q;
  logic [CHAIN_W-1:0] prev_chain_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      prev_chain_q <= '0;
    end else if (out_acc) begin
      seen_q       <= 1'b1;
      prev_chain_q <= chain_number_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(mode_x_o) && $stable(mode_y_o)
                                   && $stable(mode_z_o) && $stable(chain_number_o))
    else $error("stalled result changed");

  // One bead is worked on at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("second request taken while a bead is in progress");

  // A result never shows up on the cycle right after a bead is taken.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // Chain numbers of consecutive results count up by one.
  a_chain_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q |-> chain_number_o == prev_chain_q + 1'b1)
    else $error("chain number out of sequence");

endmodule

bind rouse_mode_projection_top rmp_checker u_rmp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .mode_x_o       (mode_x_o),
  .mode_y_o       (mode_y_o),
  .mode_z_o       (mode_z_o),
  .chain_number_o (chain_number_o)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Rouse mode projection block.
// ----------------------------------------------------------------------------
// A table of directed requests and register writes runs first. Random chains
// with random register settings follow. Every accepted bead goes through a
// local model of the cosine weighting and chain sums. Each mode vector that
// leaves the block is compared field by field with the oldest prediction.
// Requests idle and results stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import rmp_pkg::*;

  localparam int  SETTLE_CYCLES = 40;
  localparam int  DRAIN_LIMIT   = 2000;
  localparam int  RANDOM_ITEMS  = 1900;
  localparam int  BIG_PHASE     = 4;
  localparam real LIMIT_NS      = 8_000_000.0;

  // Index that no register decodes.
  localparam logic [CFG_IDX_W-1:0] REG_IDX_SPARE = 2'd3;

  localparam logic [MODE_W-1:0] MODE_POS_SAT = 48'h7FFF_FFFF_FFFF;
  localparam logic [MODE_W-1:0] MODE_NEG_SAT = 48'h8000_0000_0000;

  typedef enum logic {ROW_BEAD, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [MODE_W-1:0]  x;
    logic [MODE_W-1:0]  y;
    logic [MODE_W-1:0]  z;
    logic [CHAIN_W-1:0] chain;
  } mode_vec_t;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    logic [POS_W-1:0]     px;
    logic [POS_W-1:0]     py;
    logic [POS_W-1:0]     pz;
    logic                 typed;
    mode_vec_t            mode;
  } stim_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_idx;
  logic [CFG_W-1:0]         cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [MODE_W-1:0] mode_x;
  logic signed [MODE_W-1:0] mode_y;
  logic signed [MODE_W-1:0] mode_z;
  logic [CHAIN_W-1:0]       chain_number;

  // Model state and the register copy it works from.
  logic [COUNT_W-1:0] cur_bead_count;
  logic [STEP_W-1:0]  cur_angle_step;
  logic [NORM_W-1:0]  cur_norm_scale;
  int                 bead_pos;
  logic [STEP_W-1:0]  phase_acc;
  longint             acc_x, acc_y, acc_z;
  logic [CHAIN_W-1:0] chain_cnt;

  mode_vec_t pending_modes[$];
  int        n_errors;
  int        n_requests;
  int        n_modes;
  int        n_cfg_writes;
  logic      dirty;
  logic      no_gaps;

  rouse_mode_projection_top i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .pos_z_i        (pos_z),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .mode_x_o       (mode_x),
    .mode_y_o       (mode_y),
    .mode_z_o       (mode_z),
    .chain_number_o (chain_number)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Model of the block
  // --------------------------------------------------------------------------
  function automatic longint atan_step(input int i);
    case (i)
      0:  return 536870912;
      1:  return 316933406;
      2:  return 167458907;
      3:  return 85004756;
      4:  return 42667331;
      5:  return 21354465;
      6:  return 10679838;
      7:  return 5340245;
      8:  return 2670163;
      9:  return 1335087;
      10: return 667544;
      11: return 333772;
      12: return 166886;
      13: return 83443;
      14: return 41722;
      15: return 20861;
      16: return 10430;
      17: return 5215;
      18: return 2608;
      19: return 1304;
      20: return 652;
      21: return 326;
      22: return 163;
      23: return 81;
      default: return 0;
    endcase
  endfunction

  // Cosine of a Q0.32 turn angle, rounded to Q.16.
  function automatic longint cos_turns(input logic [31:0] ang);
    logic [31:0] a;
    logic [31:0] probe;
    logic        flip;
    longint      x, y, z, nx;
    a     = ang;
    x     = 652032874;
    y     = 0;
    probe = a + 32'h4000_0000;
    flip  = probe[31];
    // Angles outside the right half-plane are rotated by half a turn.
    if (flip) begin
      a = a - 32'h8000_0000;
    end
    z = longint'($signed(a));
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_step(i);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_step(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
    end
    return (x + 8192) >>> 14;
  endfunction

  function automatic longint sat_add64(input longint a, input longint b);
    logic [64:0] t;
    t = {a[63], a} + {b[63], b};
    if (t[64] != t[63]) begin
      return t[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    return t[63:0];
  endfunction

  function automatic logic [MODE_W-1:0] scale_to_mode(input longint s,
                                                      input logic [NORM_W-1:0] k);
    logic signed [81:0] p;
    p = s * $signed({1'b0, k});
    p = (p + (82'sd1 <<< 31)) >>> 32;
    if (p > 82'sd140737488355327) begin
      return MODE_POS_SAT;
    end
    if (p < -82'sd140737488355328) begin
      return MODE_NEG_SAT;
    end
    return p[MODE_W-1:0];
  endfunction

  function automatic int eff_len();
    if (cur_bead_count < 2) begin
      return 2;
    end
    if (cur_bead_count > MAX_BEADS) begin
      return MAX_BEADS;
    end
    return int'(cur_bead_count);
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] data);
    case (idx)
      REG_BEAD_COUNT: cur_bead_count = data[COUNT_W-1:0];
      REG_ANGLE_STEP: cur_angle_step = data[STEP_W-1:0];
      REG_NORM_SCALE: cur_norm_scale = data[NORM_W-1:0];
      default: ;
    endcase
  endfunction

  // Adds one bead to the chain sums; reports a mode vector at the chain end.
  function automatic void project_bead(input logic [POS_W-1:0] px, py, pz,
                                       output logic done, output mode_vec_t mv);
    logic [24:0] ang25;
    longint      w;
    int          len;
    len   = eff_len();
    ang25 = {phase_acc, 1'b0} + {1'b0, cur_angle_step};
    w     = cos_turns({ang25, 7'b0});
    acc_x = sat_add64(acc_x, longint'($signed(px)) * w);
    acc_y = sat_add64(acc_y, longint'($signed(py)) * w);
    acc_z = sat_add64(acc_z, longint'($signed(pz)) * w);
    mv    = '0;
    done  = (bead_pos + 1 >= len);
    if (done) begin
      mv.x      = scale_to_mode(acc_x, cur_norm_scale);
      mv.y      = scale_to_mode(acc_y, cur_norm_scale);
      mv.z      = scale_to_mode(acc_z, cur_norm_scale);
      mv.chain  = chain_cnt;
      chain_cnt = chain_cnt + 1'b1;
      bead_pos  = 0;
      phase_acc = '0;
      acc_x     = 0;
      acc_y     = 0;
      acc_z     = 0;
    end else begin
      bead_pos  = bead_pos + 1;
      phase_acc = phase_acc + cur_angle_step;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] data);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic stim_row_t bead_row(input logic [POS_W-1:0] px, py, pz);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_BEAD;
    r.px   = px;
    r.py   = py;
    r.pz   = pz;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [POS_W-1:0] px, py, pz,
                                          input mode_vec_t mv);
    stim_row_t r;
    r       = bead_row(px, py, pz);
    r.typed = 1'b1;
    r.mode  = mv;
    return r;
  endfunction

  function automatic int idle_gap();
    int k;
    if (no_gaps) begin
      return 0;
    end
    k = $urandom_range(99);
    if (k < 55) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [POS_W-1:0] rand_pos(input int flavor);
    int k;
    k = $urandom_range(99);
    if (flavor == 0 || k < 10) begin
      case ($urandom_range(4))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        3:       return 32'hFFFF_FFFF;
        default: return $urandom;
      endcase
    end
    if (flavor == 1) begin
      return $urandom;
    end
    return 32'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
  endfunction

  task automatic report_mismatch(input string what, input logic [MODE_W-1:0] got,
                                 input logic [MODE_W-1:0] want);
    n_errors++;
    if (n_errors <= 40) begin
      $display("mismatch: %s got %h want %h at %0t", what, got, want, $time);
    end
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_cfg(idx, data);
    n_cfg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Holds the request until it is taken, then books its prediction.
  task automatic send_bead(input logic [POS_W-1:0] px, py, pz,
                           input logic typed, input mode_vec_t typed_mv);
    int        gap;
    logic      done;
    mode_vec_t mv;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x    <= px;
    pos_y    <= py;
    pos_z    <= pz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    project_bead(px, py, pz, done, mv);
    if (done) begin
      pending_modes.push_back(typed ? typed_mv : mv);
    end
    n_requests++;
    dirty = 1'b1;
  endtask

  // The sender pauses until every predicted vector has come out and the
  // block has finished any bead still in flight.
  task automatic wait_idle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_modes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_modes.size() != 0) begin
      report_mismatch("mode vectors never delivered, count",
                      MODE_W'(pending_modes.size()), '0);
      pending_modes.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    dirty = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall and the checker
  // --------------------------------------------------------------------------
  initial begin : stall_gen
    int k;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(6) == 0) begin
        repeat ($urandom_range(100, 300)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_stall <= 1'b1;
      k = $urandom_range(99);
      if (k < 80) begin
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else if (k < 97) begin
        repeat ($urandom_range(4, 10)) @(posedge clk);
      end else begin
        repeat ($urandom_range(20, 50)) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : mode_check
    mode_vec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_modes.size() == 0) begin
        report_mismatch("mode vector with nothing pending, chain",
                        MODE_W'(chain_number), '0);
      end else begin
        want = pending_modes.pop_front();
        n_modes++;
        if (mode_x !== want.x) report_mismatch("mode_x", mode_x, want.x);
        if (mode_y !== want.y) report_mismatch("mode_y", mode_y, want.y);
        if (mode_z !== want.z) report_mismatch("mode_z", mode_z, want.z);
        if (chain_number !== want.chain) begin
          report_mismatch("chain_number", MODE_W'(chain_number), MODE_W'(want.chain));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t          rows[$];
    int                 len, rem, n, k, flavor, rand_items, phase, big_beads;
    logic               big;
    logic [COUNT_W-1:0] cnt;
    logic [STEP_W-1:0]  step;
    logic [NORM_W-1:0]  norm;
    real                rn;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    pos_x          = '0;
    pos_y          = '0;
    pos_z          = '0;
    n_errors       = 0;
    n_requests     = 0;
    n_modes        = 0;
    n_cfg_writes   = 0;
    dirty          = 1'b0;
    no_gaps        = 1'b0;
    cur_bead_count = BEAD_COUNT_RST;
    cur_angle_step = ANGLE_STEP_RST;
    cur_norm_scale = NORM_SCALE_RST;
    bead_pos       = 0;
    phase_acc      = '0;
    acc_x          = 0;
    acc_y          = 0;
    acc_z          = 0;
    chain_cnt      = '0;
    rand_items     = 0;
    big_beads      = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One full chain on the reset settings, with extreme coordinates.
    rows.push_back(bead_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000));
    rows.push_back(bead_row(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    rows.push_back(bead_row(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001));
    rows.push_back(bead_row(32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF));
    rows.push_back(bead_row(32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000));
    rows.push_back(bead_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333));
    rows.push_back(bead_row(32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC));
    rows.push_back(bead_row(32'h0000_8000, 32'hFFFF_8000, 32'h0002_4000));
    rows.push_back(bead_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    rows.push_back(bead_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    rows.push_back(bead_row(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F));
    rows.push_back(bead_row(32'hF0F0_F0F0, 32'h0000_FFFF, 32'hFFFF_0000));
    rows.push_back(bead_row(32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF));
    rows.push_back(bead_row(32'h7FFF_0000, 32'h8000_FFFF, 32'h0000_0000));
    rows.push_back(bead_row(32'h0003_0000, 32'hFFFD_0000, 32'h0001_8000));
    rows.push_back(bead_row(32'h4000_0000, 32'hC000_0000, 32'h2000_0000));
    // A length of zero acts as two; a zero angle with full scale gives the
    // largest weights and the largest scaled sums.
    rows.push_back(cfg_row(REG_BEAD_COUNT, 24'd0));
    rows.push_back(cfg_row(REG_ANGLE_STEP, 24'd0));
    rows.push_back(cfg_row(REG_NORM_SCALE, 24'd65535));
    rows.push_back(bead_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000));
    rows.push_back(bead_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000));
    // A length of one acts as two; a zero scale clears every component.
    rows.push_back(cfg_row(REG_BEAD_COUNT, 24'd1));
    rows.push_back(cfg_row(REG_NORM_SCALE, 24'd0));
    rows.push_back(bead_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    rows.push_back(typed_row(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                             mode_vec_t'{48'h0, 48'h0, 48'h0, 16'd2}));
    // A write to the undecoded index must leave all registers alone.
    rows.push_back(cfg_row(REG_IDX_SPARE, 24'hFF_FFFF));
    rows.push_back(cfg_row(REG_BEAD_COUNT, 24'd3));
    rows.push_back(cfg_row(REG_ANGLE_STEP, 24'hFF_FFFF));
    rows.push_back(bead_row(32'h0001_0000, 32'hFFFD_8000, 32'h7FFF_FFFF));
    rows.push_back(bead_row(32'h0002_0000, 32'h0000_4000, 32'h8000_0000));
    rows.push_back(bead_row(32'hFFFF_0000, 32'h0001_2345, 32'h0000_0000));
    // Shortening the chain and changing the angle in the middle of a chain.
    rows.push_back(cfg_row(REG_BEAD_COUNT, 24'd5));
    rows.push_back(cfg_row(REG_ANGLE_STEP, 24'h15_5555));
    rows.push_back(cfg_row(REG_NORM_SCALE, 24'd41449));
    rows.push_back(bead_row(32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000));
    rows.push_back(bead_row(32'h0020_0000, 32'h0008_0000, 32'hFFFF_8000));
    rows.push_back(cfg_row(REG_BEAD_COUNT, 24'd2));
    rows.push_back(cfg_row(REG_ANGLE_STEP, 24'h40_0000));
    rows.push_back(bead_row(32'h0030_0000, 32'hFFE0_0000, 32'h0001_0000));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        if (dirty) wait_idle();
        write_cfg(rows[i].idx, rows[i].data);
      end else begin
        send_bead(rows[i].px, rows[i].py, rows[i].pz, rows[i].typed, rows[i].mode);
      end
    end

    // Random phases: new settings, then mostly whole chains.
    phase = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (dirty) wait_idle();
      no_gaps = ($urandom_range(4) == 0);
      big     = (phase == BIG_PHASE);

      // A chain left open under an over-long setting is always shortened.
      if (big || eff_len() > 300 || $urandom_range(1) == 1) begin
        k = $urandom_range(99);
        if (big)         cnt = 13'($urandom_range(MAX_BEADS + 1, 8191));
        else if (k < 10) cnt = 13'($urandom_range(1));
        else if (k < 60) cnt = 13'($urandom_range(2, 8));
        else if (k < 90) cnt = 13'($urandom_range(9, 40));
        else             cnt = 13'($urandom_range(41, 300));
        // Bits above the register width must be dropped by the block.
        write_cfg(REG_BEAD_COUNT,
                  {($urandom_range(4) == 0) ? 11'($urandom) : 11'd0, cnt});
      end
      len = eff_len();
      if ($urandom_range(1) == 1) begin
        k = $urandom_range(99);
        if (k < 20)      step = '0;
        else if (k < 30) step = 24'hFF_FFFF;
        else if (k < 75) step = 24'((longint'($urandom_range(0, len - 1)) << 23) / len);
        else             step = 24'($urandom);
        write_cfg(REG_ANGLE_STEP, step);
      end
      if ($urandom_range(1) == 1) begin
        k  = $urandom_range(99);
        rn = $sqrt(2.0 / len) * 65536.0;
        if (k < 15)      norm = '0;
        else if (k < 30) norm = 16'hFFFF;
        else if (k < 70) norm = (rn >= 65535.0) ? 16'hFFFF : 16'(int'(rn));
        else             norm = 16'($urandom);
        write_cfg(REG_NORM_SCALE,
                  {($urandom_range(4) == 0) ? 8'($urandom) : 8'd0, norm});
      end
      if ($urandom_range(9) == 0) begin
        write_cfg(REG_IDX_SPARE, 24'($urandom));
      end

      rem = (bead_pos + 1 >= len) ? 1 : len - bead_pos;
      if (big)                          n = $urandom_range(20, 120);
      else if (len > 40)                n = rem;
      else if ($urandom_range(4) != 0)  n = rem + len * $urandom_range(0, 3);
      else                              n = $urandom_range(1, len);
      flavor = $urandom_range(2);
      repeat (n) begin
        send_bead(rand_pos(flavor), rand_pos(flavor), rand_pos(flavor), 1'b0,
                  mode_vec_t'('0));
      end
      rand_items += n;
      if (big) big_beads += n;
      phase++;
    end

    wait_idle();
    $display("summary: %0d bead requests (%0d under an over-long chain setting), %0d mode vectors",
             n_requests, big_beads, n_modes);
    $display("summary: %0d register writes over %0d random phases", n_cfg_writes, phase);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rmp_pkg.sv
rtl/rmp_ctrl.sv
rtl/rmp_datapath.sv
rtl/rouse_mode_projection_top.sv
rtl/rmp_checker.sv
sim/tb_top.sv
